/* rtl/spq_pkg.sv */
// ============================================================================
// spq_pkg: shared types and constants for the stable priority queue
// Field widths, command and status codes, slot layout, sequencer states.
// ============================================================================
package spq_pkg;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 16;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPGRADE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] order;
    } slot_t;

    typedef enum logic [1:0] {
        SCAN_FREE,
        SCAN_MIN,
        SCAN_MATCH
    } scan_mode_t;

    typedef struct packed {
        logic       clr;
        logic       in_valid;
        scan_mode_t mode;
    } scan_ctl_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_CLEAR,
        S_APPLY
    } state_t;

endpackage

/* rtl/spq_mem.sv */
// ============================================================================
// spq_mem: slot storage
// One write port, one read port with registered read data.
// ============================================================================
module spq_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  spq_pkg::slot_t  wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output spq_pkg::slot_t  rdata
);
    import spq_pkg::*;

    slot_t mem_reg [DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/spq_scan.sv */
// ============================================================================
// spq_scan: shared compare unit
// Takes one slot per cycle in index order and keeps the best one for the mode:
// first free slot, most urgent entry, or earliest-inserted id match.
// ============================================================================
module spq_scan #(
    parameter int IW = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  spq_pkg::scan_ctl_t           ctl,
    input  logic [IW-1:0]                in_idx,
    input  spq_pkg::slot_t               in_slot,
    input  logic [spq_pkg::ID_W-1:0]     key_id,
    output logic                         found,
    output logic [IW-1:0]                best_idx,
    output spq_pkg::slot_t               best_slot
);
    import spq_pkg::*;

    logic          found_reg;
    logic          found_next;
    logic [IW-1:0] best_idx_reg;
    slot_t         best_slot_reg;
    logic          cand;
    logic          better;
    logic          take;

    always_comb
    begin
        cand   = 1'b0;
        better = 1'b0;
        case (ctl.mode)
            SCAN_FREE:
            begin
                cand   = !in_slot.valid;
                better = !found_reg;
            end
            SCAN_MIN:
            begin
                cand   = in_slot.valid;
                better = !found_reg
                      || (in_slot.prio < best_slot_reg.prio)
                      || ((in_slot.prio == best_slot_reg.prio)
                          && (in_slot.stamp < best_slot_reg.stamp));
            end
            SCAN_MATCH:
            begin
                cand   = in_slot.valid && (in_slot.id == key_id);
                better = !found_reg || (in_slot.order < best_slot_reg.order);
            end
            default:
            begin
                cand   = 1'b0;
                better = 1'b0;
            end
        endcase
    end

    // strict compares: on a full tie the lower index, seen first, stays
    assign take = ctl.in_valid && cand && better;

    always_comb
    begin
        found_next = found_reg;
        if (ctl.clr)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !ctl.clr)
        begin
            best_idx_reg  <= in_idx;
            best_slot_reg <= in_slot;
        end
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_slot = best_slot_reg;

endmodule

/* rtl/stable_priority_queue_top.sv */
// ============================================================================
// stable_priority_queue_top: bounded priority queue with stable tie-break
// Unsorted slot array; a sequencer scans the slots through one compare unit.
// ============================================================================
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  command   | start, busy            | cmd, entry_id, priority_req
//  result    | done (one-cycle pulse) | out_id, out_priority, status,
//            |                        | occupancy
//
//  A command transfer happens at a rising edge with start high and busy low.
//  Insert, pop, peek and upgrade scan all CAPACITY slots through the shared
//  compare unit, one slot per cycle from the single read port. Full insert,
//  empty pop or peek and unused codes skip the scan; clear sweeps the slots.
//  After reset the block clears the slot memory with busy high. busy drops
//  in the cycle done is shown; results are never stalled.
//
module stable_priority_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [spq_pkg::CMD_W-1:0]        cmd,
    input  logic [spq_pkg::ID_W-1:0]         entry_id,
    input  logic [spq_pkg::PRIO_W-1:0]       priority_req,
    output logic                             done,
    output logic [spq_pkg::ID_W-1:0]         out_id,
    output logic [spq_pkg::PRIO_W-1:0]       out_priority,
    output logic [spq_pkg::STATUS_W-1:0]     status,
    output logic [spq_pkg::OCC_W-1:0]        occupancy
);
    import spq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    // sequencer
    state_t            state_reg, state_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic              cnt_last;
    logic              accept;

    // read tag: data of slot tag_idx_reg is on the memory output
    logic              tag_valid_reg;
    logic [IW-1:0]     tag_idx_reg;

    // latched command
    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PRIO_W-1:0] prio_reg;

    // queue state
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic [CW-1:0]      count_reg, count_next;

    // result registers
    logic                done_reg;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic [PRIO_W-1:0]   out_prio_reg, out_prio_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OCC_W-1:0]    occ_reg;

    // memory and compare unit
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    slot_t         mem_wdata;
    logic          mem_re;
    slot_t         mem_rdata;
    scan_ctl_t     scan_ctl;
    logic          scan_found;
    logic [IW-1:0] scan_idx;
    slot_t         scan_slot;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign cnt_last = (cnt_reg == LAST_IDX);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd) inside
                        CMD_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        CMD_INSERT:
                        begin
                            state_next = (count_reg == FULL_CNT) ? S_APPLY : S_SCAN;
                        end
                        CMD_POP, CMD_PEEK:
                        begin
                            state_next = (count_reg == '0) ? S_APPLY : S_SCAN;
                        end
                        CMD_UPGRADE:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_APPLY;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cnt_last)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_APPLY;
            end
            S_CLEAR:
            begin
                if (cnt_last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        cnt_next      = '0;
        mem_we        = 1'b0;
        mem_waddr     = cnt_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        stamp_next    = stamp_reg;
        count_next    = count_reg;
        out_id_next   = '0;
        out_prio_next = '0;
        status_next   = STAT_OK;

        scan_ctl.clr      = accept;
        scan_ctl.in_valid = tag_valid_reg;
        unique case (cmd_reg) inside
            CMD_POP, CMD_PEEK:
            begin
                scan_ctl.mode = SCAN_MIN;
            end
            CMD_UPGRADE:
            begin
                scan_ctl.mode = (count_reg == '0) ? SCAN_FREE : SCAN_MATCH;
            end
            default:
            begin
                scan_ctl.mode = SCAN_FREE;
            end
        endcase

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                cnt_next  = cnt_last ? '0 : cnt_reg + 1'b1;
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = '0;
            end
            S_SCAN:
            begin
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
                mem_re   = 1'b1;
            end
            S_APPLY:
            begin
                mem_waddr = scan_idx;
                unique case (cmd_reg) inside
                    CMD_INSERT, CMD_UPGRADE:
                    begin
                        if (cmd_reg == CMD_UPGRADE && count_reg != '0)
                        begin
                            // new priority and stamp on the earliest match
                            if (scan_found)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = scan_slot;
                                mem_wdata.prio  = prio_reg;
                                mem_wdata.stamp = stamp_reg;
                                stamp_next      = stamp_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = STAT_NOTFOUND;
                            end
                        end
                        else if (count_reg == FULL_CNT)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            // lowest free slot, one stamp for both stamp and order
                            mem_we          = 1'b1;
                            mem_wdata.valid = 1'b1;
                            mem_wdata.id    = id_reg;
                            mem_wdata.prio  = prio_reg;
                            mem_wdata.stamp = stamp_reg;
                            mem_wdata.order = stamp_reg;
                            stamp_next      = stamp_reg + 1'b1;
                            count_next      = count_reg + 1'b1;
                        end
                    end
                    CMD_POP, CMD_PEEK:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            out_id_next   = scan_slot.id;
                            out_prio_next = scan_slot.prio;
                            if (cmd_reg == CMD_POP)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = scan_slot;
                                mem_wdata.valid = 1'b0;
                                count_next      = count_reg - 1'b1;
                            end
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            tag_valid_reg <= 1'b0;
            stamp_reg     <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tag_valid_reg <= (state_reg == S_SCAN);
            stamp_reg     <= stamp_next;
            count_reg     <= count_next;
            done_reg      <= (state_reg == S_APPLY);
        end
    end

    always_ff @(posedge clk)
    begin
        tag_idx_reg <= cnt_reg;
        if (accept)
        begin
            cmd_reg  <= cmd;
            id_reg   <= entry_id;
            prio_reg <= priority_req;
        end
        if (state_reg == S_APPLY)
        begin
            out_id_reg   <= out_id_next;
            out_prio_reg <= out_prio_next;
            status_reg   <= status_next;
            occ_reg      <= OCC_W'(count_next);
        end
    end

    // ---------------- datapath units ----------------
    spq_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cnt_reg),
        .rdata (mem_rdata)
    );

    spq_scan #(
        .IW (IW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .in_idx    (tag_idx_reg),
        .in_slot   (mem_rdata),
        .key_id    (id_reg),
        .found     (scan_found),
        .best_idx  (scan_idx),
        .best_slot (scan_slot)
    );

    assign done         = done_reg;
    assign out_id       = out_id_reg;
    assign out_priority = out_prio_reg;
    assign status       = status_reg;
    assign occupancy    = occ_reg;

endmodule
